>>> design/xbc_pkg.sv
// ----------------------------------------------------------------------------
// XTEA block cipher shared definitions
// Constants, the per-cell lane record and the padding helpers.
// ----------------------------------------------------------------------------
package xbc_pkg;

  localparam int unsigned NUM_KEYS = 4;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned BLK_W    = 64;
  localparam int unsigned BV_W     = 4;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic [BV_W-1:0]  BYTES_FULL = 4'd8;
  localparam logic [BLK_W-1:0] PAD_BLOCK  = 64'h0808_0808_0808_0808;

  typedef logic [NUM_KEYS-1:0][DATA_W-1:0] key_t;

  typedef struct packed {
    logic        op;
    logic        last;
    logic [31:0] v0;
    logic [31:0] v1;
  } lane_t;

  function automatic logic [31:0] mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Replace bytes n..7 with the pad count 8 - n; n of 8 or more leaves the block
  function automatic logic [BLK_W-1:0] pad_block(input logic [BLK_W-1:0] blk,
                                                 input logic [BV_W-1:0]  n);
    logic [BLK_W-1:0] res;
    logic [7:0]       pad;
    res = blk;
    pad = 8'd8 - {4'd0, n};
    if (!n[3]) begin
      for (int i = 0; i < 8; i++) begin
        if (i >= int'(n)) begin
          res[8*i +: 8] = pad;
        end
      end
    end
    return res;
  endfunction

  // Count of bytes kept once a well-formed pad is stripped, else a full block
  function automatic logic [BV_W-1:0] pad_check(input logic [BLK_W-1:0] d);
    logic [7:0] p;
    logic       ok;
    p  = d[63:56];
    ok = (p >= 8'd1) && (p <= 8'd8);
    for (int i = 0; i < 8; i++) begin
      if ((i >= 8 - int'(p)) && (d[8*i +: 8] != p)) begin
        ok = 1'b0;
      end
    end
    return ok ? BV_W'(8'd8 - p) : BYTES_FULL;
  endfunction

endpackage

>>> design/xbc_in_if.sv
// ----------------------------------------------------------------------------
// XTEA request channel
// Valid/ready channel carrying one block request.
// ----------------------------------------------------------------------------
interface xbc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] block_data;
  logic        last_block;
  logic [3:0]  bytes_valid;

  modport source (output valid, opcode, block_data, last_block, bytes_valid,
                  input ready);
  modport sink   (input valid, opcode, block_data, last_block, bytes_valid,
                  output ready);
endinterface

>>> design/xbc_out_if.sv
// ----------------------------------------------------------------------------
// XTEA result channel
// Valid/ready channel carrying one processed block.
// ----------------------------------------------------------------------------
interface xbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_data;
  logic        result_last;
  logic [3:0]  result_bytes_valid;

  modport source (output valid, result_data, result_last, result_bytes_valid,
                  input ready);
  modport sink   (input valid, result_data, result_last, result_bytes_valid,
                  output ready);
endinterface

>>> design/xbc_cfg.sv
// ----------------------------------------------------------------------------
// XTEA key registers
// APB-style register file holding the four 32-bit key words.
// ----------------------------------------------------------------------------
module xbc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xbc_pkg::ADDR_W-1:0] paddr,
  input  logic [xbc_pkg::DATA_W-1:0] pwdata,
  output logic [xbc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output xbc_pkg::key_t              keys
);

  xbc_pkg::key_t key_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = key_r[paddr[3:2]];
  assign keys   = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (wr_en) begin
      key_r[paddr[3:2]] <= pwdata;
    end
  end

endmodule

>>> design/xbc_cell.sv
// ----------------------------------------------------------------------------
// XTEA half-round cell
// Applies one Feistel half-round, encrypt or decrypt, and hands on the lane.
// ----------------------------------------------------------------------------
module xbc_cell #(
  parameter logic [31:0] ENC_SUM = 32'd0,
  parameter logic [31:0] DEC_SUM = 32'd0,
  parameter bit          ODD     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  xbc_pkg::key_t        keys,
  input  logic                 in_valid,
  input  xbc_pkg::lane_t       in_lane,
  output logic                 out_valid,
  output xbc_pkg::lane_t       out_lane
);

  logic           valid_r;
  xbc_pkg::lane_t lane_r;
  xbc_pkg::lane_t lane_nxt;
  logic           enc;
  logic           dst_v0;
  logic [31:0]    sum;
  logic [1:0]     kidx;
  logic [31:0]    src;
  logic [31:0]    dst;
  logic [31:0]    f;
  logic [31:0]    upd;

  always_comb begin
    enc    = (in_lane.op == xbc_pkg::OP_ENC);
    dst_v0 = enc ^ ODD;
    sum    = enc ? ENC_SUM : DEC_SUM;
    kidx   = dst_v0 ? sum[1:0] : sum[12:11];
    src    = dst_v0 ? in_lane.v1 : in_lane.v0;
    dst    = dst_v0 ? in_lane.v0 : in_lane.v1;
    f      = xbc_pkg::mix(src) ^ (sum + keys[kidx]);
    upd    = enc ? (dst + f) : (dst - f);
    lane_nxt = in_lane;
    if (dst_v0) begin
      lane_nxt.v0 = upd;
    end else begin
      lane_nxt.v1 = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;

endmodule

>>> design/xtea_block_cipher_padded_core.sv
// ----------------------------------------------------------------------------
// XTEA block cipher with end-of-message padding
// Requests enter on in_chan (opcode, block_data, last_block, bytes_valid);
// results leave on out_chan (result_data, result_last, result_bytes_valid).
// The key is written through the APB port: key word i at byte address 4*i.
// Write the key only while no request is in flight.
// The data path is a chain of 2*ROUNDS half-round cells, one per Feistel
// half, followed by an output register that also checks the decrypt pad.
// One request is taken per cycle while the chain advances and no pad block
// is pending; a full final encrypt block issues a second pad block into the
// chain and holds in_chan.ready low until that pad block has entered it.
// When out_chan is stalled the output register holds its result; the chain
// keeps moving while its last cell is empty and freezes once it is full.
// Reset clears the key words, all valid flags and the pending pad block.
// ----------------------------------------------------------------------------
module xtea_block_cipher_padded_core #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  xbc_in_if.sink                     in_chan,
  xbc_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xbc_pkg::ADDR_W-1:0] paddr,
  input  logic [xbc_pkg::DATA_W-1:0] pwdata,
  output logic [xbc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned NCELL = 2 * ROUNDS;

  xbc_pkg::key_t  keys;
  logic           cell_v    [0:NCELL];
  xbc_pkg::lane_t cell_lane [0:NCELL];
  logic           head_v;
  xbc_pkg::lane_t head_lane;

  logic           pend_r;
  logic           pend_nxt;
  logic           adv;
  logic           out_take;
  logic           in_acc;
  logic           full_last;
  logic [63:0]    blk;

  logic                       out_valid_r;
  logic [63:0]                out_data_r;
  logic                       out_last_r;
  logic [xbc_pkg::BV_W-1:0]   out_bv_r;
  logic [63:0]                fin_data;
  logic [xbc_pkg::BV_W-1:0]   fin_bv;

  xbc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys    (keys)
  );

  assign out_take = !out_valid_r || out_chan.ready;
  assign adv      = !cell_v[NCELL] || out_take;
  assign in_chan.ready = adv && !pend_r;
  assign in_acc   = in_chan.valid && in_chan.ready;

  always_comb begin
    full_last = (in_chan.opcode == xbc_pkg::OP_ENC) && in_chan.last_block &&
                in_chan.bytes_valid[3];
    blk       = in_chan.block_data;
    if ((in_chan.opcode == xbc_pkg::OP_ENC) && in_chan.last_block) begin
      blk = xbc_pkg::pad_block(in_chan.block_data, in_chan.bytes_valid);
    end
    pend_nxt = pend_r;
    if (pend_r) begin
      head_v         = 1'b1;
      head_lane.op   = xbc_pkg::OP_ENC;
      head_lane.last = 1'b1;
      head_lane.v0   = xbc_pkg::PAD_BLOCK[31:0];
      head_lane.v1   = xbc_pkg::PAD_BLOCK[63:32];
      if (adv) begin
        pend_nxt = 1'b0;
      end
    end else begin
      head_v         = in_acc;
      head_lane.op   = in_chan.opcode;
      head_lane.last = in_chan.last_block && !full_last;
      head_lane.v0   = blk[31:0];
      head_lane.v1   = blk[63:32];
      if (in_acc && full_last) begin
        pend_nxt = 1'b1;
      end
    end
  end

  assign cell_v[0]    = head_v;
  assign cell_lane[0] = head_lane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    localparam int unsigned R   = j / 2;
    localparam int unsigned H   = j % 2;
    localparam logic [63:0] ENC_P = 64'(R + H) * 64'(xbc_pkg::DELTA);
    localparam logic [63:0] DEC_P = 64'(ROUNDS - R - H) * 64'(xbc_pkg::DELTA);

    xbc_cell #(
      .ENC_SUM (ENC_P[31:0]),
      .DEC_SUM (DEC_P[31:0]),
      .ODD     (H == 1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .keys      (keys),
      .in_valid  (cell_v[j]),
      .in_lane   (cell_lane[j]),
      .out_valid (cell_v[j+1]),
      .out_lane  (cell_lane[j+1])
    );
  end

  always_comb begin
    fin_data = {cell_lane[NCELL].v1, cell_lane[NCELL].v0};
    fin_bv   = xbc_pkg::BYTES_FULL;
    if ((cell_lane[NCELL].op == xbc_pkg::OP_DEC) && cell_lane[NCELL].last) begin
      fin_bv = xbc_pkg::pad_check(fin_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= cell_v[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= fin_data;
      out_last_r <= cell_lane[NCELL].last;
      out_bv_r   <= fin_bv;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.result_data        = out_data_r;
  assign out_chan.result_last        = out_last_r;
  assign out_chan.result_bytes_valid = out_bv_r;

endmodule
